>>> src/swipe_gesture_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the swipe gesture classifier
// Clocked concurrent checks on clk_i, with or without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef SWIPE_GESTURE_CLASSIFIER_ASSERT_SVH
`define SWIPE_GESTURE_CLASSIFIER_ASSERT_SVH

// Check that is switched off while rst_ni is low.
`define SWG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that also holds while rst_ni is low.
`define SWG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/swg_pkg.sv
// ----------------------------------------------------------------------------
// swg_pkg
// Types and constants shared by the swipe gesture classifier modules.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int unsigned LevelWidth  = 8;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned ThrWidth    = 8;
  localparam int unsigned GestWidth   = 3;
  localparam int unsigned InDataWidth = 4 * LevelWidth;
  localparam int unsigned OutDataWidth = 8;
  localparam logic [ThrWidth-1:0] ThrReset = ThrWidth'(13);

  typedef enum logic [GestWidth-1:0] {
    GESTURE_NONE  = 3'd0,
    GESTURE_UP    = 3'd1,
    GESTURE_DOWN  = 3'd2,
    GESTURE_LEFT  = 3'd3,
    GESTURE_RIGHT = 3'd4
  } gesture_e;

  typedef logic [CountWidth-1:0] count_t;

  // One input point or event
  typedef struct packed {
    logic                  mode;       // 1 = no-data event
    logic [LevelWidth-1:0] up_level;
    logic [LevelWidth-1:0] down_level;
    logic [LevelWidth-1:0] left_level;
    logic [LevelWidth-1:0] right_level;
    logic                  batch_end;
  } swg_item_t;

  // Per-item outcome of the classifier
  typedef struct packed {
    logic     emit;
    gesture_e gesture;
  } swg_result_t;

  // Classifier state summary
  typedef struct packed {
    logic all_clear;  // all four counters zero
    logic dropping;
  } swg_status_t;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (&c) ? c : c + count_t'(1);
  endfunction

endpackage

>>> src/swipe_gesture_classifier.sv
// ----------------------------------------------------------------------------
// swipe_gesture_classifier
// Swipe classifier for batched four-photodiode gesture points.
// ----------------------------------------------------------------------------
// Points enter on the slave stream, one per beat, and pass an input register,
// the classification logic and an output register. The block takes
// one beat per cycle when the master side keeps tready high. Each point
// forms v = up - down and h = left - right and tests them against +/- the
// threshold register; an edge against a nonzero opposite counter reports
// a swipe, clears the counters and skips the rest of the batch. A batch
// that ends with no swipe reports none (code 0), and a no-data event
// (tuser high) clears the counters and reports none. Points that neither
// decide nor end a batch produce no output beat. The threshold (reset 13)
// may only be written while the block is idle.
module swipe_gesture_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Threshold register write
  input  logic                             cfg_we_i,
  input  logic [swg_pkg::ThrWidth-1:0]     cfg_wdata_i,
  // Point stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [swg_pkg::InDataWidth-1:0]  s_axis_tdata,   // up, down, left, right
  input  logic                             s_axis_tlast,   // batch_end
  input  logic                             s_axis_tuser,   // mode: 1 = no-data event
  // Gesture stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [swg_pkg::OutDataWidth-1:0] m_axis_tdata    // gesture, zero padded
);
  import swg_pkg::*;

  logic [ThrWidth-1:0] thr_q;
  swg_item_t           in_item, held_item;
  logic                held_valid;
  logic                fire;
  swg_result_t         result;
  swg_status_t         status;
  logic                out_valid_q, out_valid_d;
  gesture_e            gest_q;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Unpack the input beat, lowest field first
  assign in_item.mode        = s_axis_tuser;
  assign in_item.up_level    = s_axis_tdata[LevelWidth-1:0];
  assign in_item.down_level  = s_axis_tdata[2*LevelWidth-1:LevelWidth];
  assign in_item.left_level  = s_axis_tdata[3*LevelWidth-1:2*LevelWidth];
  assign in_item.right_level = s_axis_tdata[4*LevelWidth-1:3*LevelWidth];
  assign in_item.batch_end   = s_axis_tlast;

  swg_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (fire),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  // Advance whenever the output register is free or being drained
  assign fire = held_valid && (!out_valid_q || m_axis_tready);

  swg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .thr_i    (thr_q),
    .result_o (result),
    .status_o (status)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = result.emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && result.emit) begin
      gest_q <= result.gesture;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-GestWidth){1'b0}}, gest_q};

`include "swipe_gesture_classifier_assert.svh"

  // A no-data event leaves counters clear and the drop flag low
  `SWG_ASSERT(a_nodata_clears, (fire && held_item.mode) |=> (status.all_clear && !status.dropping), "no-data event did not clear state")
  // A swipe mid-batch starts dropping the rest of the batch
  `SWG_ASSERT(a_swipe_drops, (fire && !held_item.mode && !status.dropping && result.gesture != GESTURE_NONE && !held_item.batch_end) |=> status.dropping, "swipe did not start batch drop")
  // Backpressure on the input only comes from a held beat
  `SWG_ASSERT_ALWAYS(a_ready_full, !s_axis_tready |-> held_valid, "input stalled while empty")

endmodule

>>> src/swg_in_reg.sv
// ----------------------------------------------------------------------------
// swg_in_reg
// Input register stage: captures one beat, holds it until the core takes it.
// ----------------------------------------------------------------------------
module swg_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  swg_pkg::swg_item_t in_item_i,
  input  logic               take_i,      // core consumes the held beat
  output logic               held_valid_o,
  output swg_pkg::swg_item_t held_item_o
);
  import swg_pkg::*;

  logic      valid_q, valid_d;
  swg_item_t item_q;
  logic      load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

>>> src/swg_core.sv
// ----------------------------------------------------------------------------
// swg_core
// Direction counters, drop flag and the per-point swipe decision.
// ----------------------------------------------------------------------------
module swg_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,   // item leaves the input stage
  input  swg_pkg::swg_item_t           item_i,
  input  logic [swg_pkg::ThrWidth-1:0] thr_i,
  output swg_pkg::swg_result_t         result_o,
  output swg_pkg::swg_status_t         status_o
);
  import swg_pkg::*;

  localparam int unsigned DiffWidth = LevelWidth + 2;

  count_t up_q, down_q, left_q, right_q;
  count_t up_d, down_d, left_d, right_d;
  logic   drop_q, drop_d;

  logic signed [DiffWidth-1:0] v_diff, h_diff, thr_pos, thr_neg;
  logic v_pos, v_neg, h_pos, h_neg;
  gesture_e gest;

  assign v_diff  = $signed({2'b00, item_i.up_level}) - $signed({2'b00, item_i.down_level});
  assign h_diff  = $signed({2'b00, item_i.left_level}) - $signed({2'b00, item_i.right_level});
  assign thr_pos = $signed({2'b00, thr_i});
  assign thr_neg = -thr_pos;

  assign v_pos = v_diff > thr_pos;
  assign v_neg = v_diff < thr_neg;
  assign h_pos = h_diff > thr_pos;
  assign h_neg = h_diff < thr_neg;

  // Checks run in order; each pair is mutually exclusive, so a counter
  // bumped by the first of a pair is never tested by the second.
  always_comb begin
    gest   = GESTURE_NONE;
    up_d   = up_q;
    down_d = down_q;
    left_d = left_q;
    right_d = right_q;
    if (v_pos) begin
      if (down_q != '0) gest = GESTURE_DOWN;
      else              up_d = sat_inc(up_q);
    end
    if (v_neg && gest == GESTURE_NONE) begin
      if (up_q != '0) gest = GESTURE_UP;
      else            down_d = sat_inc(down_q);
    end
    if (h_pos && gest == GESTURE_NONE) begin
      if (right_q != '0) gest = GESTURE_RIGHT;
      else               left_d = sat_inc(left_q);
    end
    if (h_neg && gest == GESTURE_NONE) begin
      if (left_q != '0) gest = GESTURE_LEFT;
      else              right_d = sat_inc(right_q);
    end
  end

  count_t up_n, down_n, left_n, right_n;

  always_comb begin
    up_n     = up_q;
    down_n   = down_q;
    left_n   = left_q;
    right_n  = right_q;
    drop_d   = drop_q;
    result_o = '{emit: 1'b0, gesture: GESTURE_NONE};
    if (item_i.mode) begin
      up_n = '0; down_n = '0; left_n = '0; right_n = '0;
      drop_d   = 1'b0;
      result_o = '{emit: 1'b1, gesture: GESTURE_NONE};
    end else if (drop_q) begin
      if (item_i.batch_end) drop_d = 1'b0;
    end else if (gest != GESTURE_NONE) begin
      up_n = '0; down_n = '0; left_n = '0; right_n = '0;
      drop_d   = !item_i.batch_end;
      result_o = '{emit: 1'b1, gesture: gest};
    end else begin
      up_n    = up_d;
      down_n  = down_d;
      left_n  = left_d;
      right_n = right_d;
      result_o = '{emit: item_i.batch_end, gesture: GESTURE_NONE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= '0;
      down_q  <= '0;
      left_q  <= '0;
      right_q <= '0;
      drop_q  <= 1'b0;
    end else if (fire_i) begin
      up_q    <= up_n;
      down_q  <= down_n;
      left_q  <= left_n;
      right_q <= right_n;
      drop_q  <= drop_d;
    end
  end

  assign status_o.all_clear = (up_q == '0) && (down_q == '0) &&
                              (left_q == '0) && (right_q == '0);
  assign status_o.dropping  = drop_q;

endmodule

>>> sim/tb_swipe_gesture_classifier.sv
// ----------------------------------------------------------------------------
// tb_swipe_gesture_classifier
// Self-checking bench for the swipe classifier: a queued point driver, an
// in-bench gesture predictor and a scoreboarding monitor on the result stream.
// ----------------------------------------------------------------------------
// Flow: a directed batch list walks every swipe direction, threshold edges,
// dropped batch tails and no-data events. Random batches follow at several
// threshold settings (0, 255, reset value, random). Both stream sides idle in
// short random bursts. Once, the result side holds off for a long stretch so
// the pipeline backs up into the point side. The threshold is only rewritten
// with the pipeline drained.
// ----------------------------------------------------------------------------
module tb_swipe_gesture_classifier;
  import swg_pkg::*;

  localparam int DeadLimit = 2000;  // cycles with no beat on either side
  localparam int LongHold  = 300;   // one-off result side hold-off
  localparam int Drain     = 6;     // cycles past the last result

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Register write port
  logic                cfg_we    = 1'b0;
  logic [ThrWidth-1:0] cfg_wdata = '0;

  // Point side
  logic                    s_tvalid = 1'b0;
  logic                    s_axis_tready;
  swg_item_t               tx_item  = '0;
  logic [InDataWidth-1:0]  s_tdata;  // up, down, left, right from bit 0
  logic                    s_tlast;  // batch_end
  logic                    s_tuser;  // mode

  // Gesture side
  logic                    m_axis_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;  // gesture, zero padded

  assign s_tdata = {tx_item.right_level, tx_item.left_level,
                    tx_item.down_level, tx_item.up_level};
  assign s_tlast = tx_item.batch_end;
  assign s_tuser = tx_item.mode;

  swipe_gesture_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state: direction counters, tail-skip flag, threshold copy
  // --------------------------------------------------------------------------
  count_t              up_cnt, dn_cnt, lf_cnt, rt_cnt;
  bit                  skip_batch;
  logic [ThrWidth-1:0] thr_q = ThrReset;

  swg_item_t point_q[$];    // points waiting for the driver
  gesture_e  gesture_q[$];  // predicted gesture beats, oldest first

  // Stimulus knobs, set by the sequence block
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  bit no_idle       = 1'b0;
  bit want_long_hold = 1'b0;

  // Bookkeeping
  int errs      = 0;
  int beats_in  = 0;
  int beats_out = 0;
  int swipes    = 0;
  int thr_writes = 0;

  function automatic count_t bump_sat(input count_t c);
    return (c == '1) ? c : count_t'(c + 1'b1);
  endfunction

  // Returns 1 when the point produces a gesture beat, with its code in g.
  function automatic bit predict_gesture(input swg_item_t it, output gesture_e g);
    int v, h, t;
    g = GESTURE_NONE;
    if (it.mode) begin
      {up_cnt, dn_cnt, lf_cnt, rt_cnt} = '0;
      skip_batch = 1'b0;
      return 1'b1;
    end
    if (skip_batch) begin
      if (it.batch_end) skip_batch = 1'b0;
      return 1'b0;
    end
    v = int'(it.up_level) - int'(it.down_level);
    h = int'(it.left_level) - int'(it.right_level);
    t = int'(thr_q);
    // Fixed check order; counts bumped earlier are seen by later checks
    if (v > t) begin
      if (dn_cnt != 0) g = GESTURE_DOWN;
      else up_cnt = bump_sat(up_cnt);
    end
    if (g == GESTURE_NONE && v < -t) begin
      if (up_cnt != 0) g = GESTURE_UP;
      else dn_cnt = bump_sat(dn_cnt);
    end
    if (g == GESTURE_NONE && h > t) begin
      if (rt_cnt != 0) g = GESTURE_RIGHT;
      else lf_cnt = bump_sat(lf_cnt);
    end
    if (g == GESTURE_NONE && h < -t) begin
      if (lf_cnt != 0) g = GESTURE_LEFT;
      else rt_cnt = bump_sat(rt_cnt);
    end
    if (g != GESTURE_NONE) begin
      {up_cnt, dn_cnt, lf_cnt, rt_cnt} = '0;
      skip_batch = !it.batch_end;
      return 1'b1;
    end
    return it.batch_end;
  endfunction

  // --------------------------------------------------------------------------
  // Point driver: predicts on every accepted beat, then loads the next one
  // --------------------------------------------------------------------------
  int tx_gap = 0;

  always @(posedge clk_i) begin
    gesture_e  g;
    swg_item_t nxt;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready) begin
        beats_in++;
        if (predict_gesture(tx_item, g)) gesture_q.push_back(g);
      end
      if (!s_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (point_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap = $urandom_range(0, 6);  // start a burst of idle cycles
          s_tvalid <= 1'b0;
        end else begin
          nxt = point_q.pop_front();
          tx_item  <= nxt;
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gesture monitor and tready pattern
  // --------------------------------------------------------------------------
  int  hold_left = 0;
  int  rx_stall  = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    gesture_e want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        beats_out++;
        if (gesture_q.size() == 0) begin
          $error("gesture beat with nothing pending, tdata 0x%02h", m_axis_tdata);
          errs++;
        end else begin
          want = gesture_q.pop_front();
          if (want != GESTURE_NONE) swipes++;
          if (m_axis_tdata[GestWidth-1:0] !== want) begin
            $error("gesture: expected %0d, got %0d", want, m_axis_tdata[GestWidth-1:0]);
            errs++;
          end
          if (m_axis_tdata[OutDataWidth-1:GestWidth] !== '0) begin
            $error("pad: expected 0, got 0x%0h", m_axis_tdata[OutDataWidth-1:GestWidth]);
            errs++;
          end
        end
      end
      // One long hold-off, counted here, so the pipeline backs up
      if (want_long_hold && !long_hold_done) begin
        hold_left = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < rx_stall_pct) begin
        rx_stall = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a beat on either side
  int dead_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
        if (dead_cycles >= DeadLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic swg_item_t pt(input logic m, input logic [7:0] u, d, l, r,
                                   input logic last);
    swg_item_t it;
    it.mode        = m;
    it.up_level    = u;
    it.down_level  = d;
    it.left_level  = l;
    it.right_level = r;
    it.batch_end   = last;
    return it;
  endfunction

  // Two levels whose difference sits near, on or past +/- threshold
  function automatic void pick_pair(input int t, output logic [7:0] a,
                                    output logic [7:0] b);
    int d, lo, hi, bv;
    case ($urandom_range(0, 5))
      0:       d = int'($urandom_range(0, 510)) - 255;
      1:       d = t + 1 + int'($urandom_range(0, 20));
      2:       d = -(t + 1 + int'($urandom_range(0, 20)));
      3:       d = t;
      4:       d = -t;
      default: d = int'($urandom_range(0, 6)) - 3;
    endcase
    if (d > 255) d = 255;
    if (d < -255) d = -255;
    lo = (d < 0) ? -d : 0;
    hi = (d > 0) ? 255 - d : 255;
    bv = $urandom_range(hi, lo);
    b  = bv[7:0];
    a  = 8'(bv + d);
  endfunction

  function automatic swg_item_t rand_point(input logic last);
    logic [7:0] u, d, l, r;
    pick_pair(int'(thr_q), u, d);
    pick_pair(int'(thr_q), l, r);
    return pt(1'b0, u, d, l, r, last);
  endfunction

  function automatic swg_item_t rand_event();
    return pt(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom_range(0, 1)));
  endfunction

  // Mostly proper batches; some stray no-data events and batches missing tlast
  task automatic queue_random(input int n);
    int  sent, len;
    bit  broken;
    sent = 0;
    @(negedge clk_i);
    while (sent < n) begin
      if ($urandom_range(0, 99) < 5) begin
        point_q.push_back(rand_event());
        sent++;
      end else begin
        len    = $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          if (broken && i == len / 2 && $urandom_range(0, 1))
            point_q.push_back(rand_event());  // event cuts the batch
          else
            point_q.push_back(rand_point(i == len - 1 && !broken));
        end
        sent += len;
      end
    end
  endtask

  // Everything sent, every result back, then room for a pointless tail point
  task automatic wait_idle();
    do @(negedge clk_i);
    while (point_q.size() != 0 || s_tvalid || gesture_q.size() != 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrWidth-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    thr_q = val;
    thr_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    {up_cnt, dn_cnt, lf_cnt, rt_cnt} = '0;
    skip_batch = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset threshold
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    @(negedge clk_i);
    point_q.push_back(pt(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));  // no-data event
    point_q.push_back(pt(1'b0, 8'hFF, 8'h00, 8'h80, 8'h80, 1'b0));  // up edge
    point_q.push_back(pt(1'b0, 8'h00, 8'hFF, 8'h80, 8'h80, 1'b0));  // swipe up mid batch
    point_q.push_back(pt(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));  // skipped
    point_q.push_back(pt(1'b0, 8'h07, 8'h07, 8'h07, 8'h07, 1'b1));  // skipped, ends skip
    point_q.push_back(pt(1'b0, 8'd50, 8'd37, 8'h00, 8'h00, 1'b1));  // v == thr: no edge
    point_q.push_back(pt(1'b0, 8'd51, 8'd37, 8'h00, 8'h00, 1'b0));  // v == thr+1
    point_q.push_back(pt(1'b0, 8'd37, 8'd51, 8'h00, 8'h00, 1'b1));  // swipe up on tlast
    point_q.push_back(pt(1'b0, 8'h00, 8'd200, 8'd100, 8'd100, 1'b0));
    point_q.push_back(pt(1'b0, 8'd200, 8'h00, 8'd100, 8'd100, 1'b1));  // swipe down
    point_q.push_back(pt(1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
    point_q.push_back(pt(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));  // swipe left
    point_q.push_back(pt(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));  // skipped tail
    point_q.push_back(pt(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
    point_q.push_back(pt(1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1));  // swipe right
    point_q.push_back(pt(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
    point_q.push_back(pt(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));  // event clears counts
    point_q.push_back(pt(1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1));  // down only counts
    point_q.push_back(pt(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));  // counts span batches
    point_q.push_back(pt(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));  // two axes at once
    point_q.push_back(pt(1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0));  // up counts, then left
    point_q.push_back(pt(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1));  // event while skipping
    point_q.push_back(pt(1'b0, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1));
    wait_idle();

    // Zero threshold: any nonzero difference is an edge
    write_threshold('0);
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    queue_random(350);
    wait_idle();

    // Max threshold: no edge is possible
    write_threshold('1);
    queue_random(80);
    wait_idle();

    // Result side holds off while single-point batches keep coming
    write_threshold(ThrWidth'($urandom_range(1, 80)));
    @(negedge clk_i);
    want_long_hold = 1'b1;
    for (int i = 0; i < 60; i++) point_q.push_back(rand_point(1'b1));
    wait_idle();

    // Saturate the up counter inside one long batch, back to back
    write_threshold(ThrReset);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(negedge clk_i);
    for (int i = 0; i < 270; i++) begin
      logic [7:0] lvl;
      lvl = 8'($urandom);
      point_q.push_back(pt(1'b0, 8'($urandom_range(14, 255)), 8'h00, lvl, lvl, 1'b0));
    end
    point_q.push_back(pt(1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1));  // swipe up
    wait_idle();

    // Random threshold, then a closing stretch with no idling at all
    write_threshold(ThrWidth'($urandom_range(1, 254)));
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    queue_random(60);
    no_idle = 1'b1;
    queue_random(100);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (gesture_q.size() != 0) begin
      $error("%0d predicted gesture beats never arrived", gesture_q.size());
      errs++;
    end

    $display("summary: %0d point beats in, %0d gesture beats out, %0d swipes",
             beats_in, beats_out, swipes);
    $display("summary: %0d threshold writes incl. 0 and 255, one long output hold",
             thr_writes);
    if (errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> swipe_gesture_classifier.f
+incdir+src
src/swg_pkg.sv
src/swg_in_reg.sv
src/swg_core.sv
src/swipe_gesture_classifier.sv
sim/tb_swipe_gesture_classifier.sv
